[src/ebc_pkg.sv]
// Package with types, codes and decode tables for the bus-cycle processor core.
`default_nettype none
package ebc_pkg;

  localparam logic [1:0] ActStart = 2'd0;
  localparam logic [1:0] ActRead  = 2'd1;
  localparam logic [1:0] ActAck   = 2'd2;

  localparam logic [2:0] KindRead  = 3'd0;
  localparam logic [2:0] KindWrite = 3'd1;
  localparam logic [2:0] KindByte  = 3'd2;
  localparam logic [2:0] KindPair  = 3'd3;
  localparam logic [2:0] KindChar  = 3'd4;
  localparam logic [2:0] KindHalt  = 3'd5;

  localparam logic [7:0] OpNop  = 8'h00;
  localparam logic [7:0] OpHlt  = 8'h01;
  localparam logic [7:0] OpLdi  = 8'h02;
  localparam logic [7:0] OpLd   = 8'h03;
  localparam logic [7:0] OpSt   = 8'h04;
  localparam logic [7:0] OpMov  = 8'h05;
  localparam logic [7:0] OpAdd  = 8'h06;
  localparam logic [7:0] OpAdc  = 8'h07;
  localparam logic [7:0] OpAnd  = 8'h08;
  localparam logic [7:0] OpJmp  = 8'h09;
  localparam logic [7:0] OpOut  = 8'h0A;
  localparam logic [7:0] OpCmpi = 8'h0B;
  localparam logic [7:0] OpJz   = 8'h0C;
  localparam logic [7:0] OpJnn  = 8'h0D;
  localparam logic [7:0] OpLdr  = 8'h0E;
  localparam logic [7:0] OpStr  = 8'h0F;
  localparam logic [7:0] OpLdp  = 8'h10;
  localparam logic [7:0] OpStp  = 8'h11;
  localparam logic [7:0] OpAddw = 8'h12;
  localparam logic [7:0] OpAddi = 8'h13;
  localparam logic [7:0] OpOutw = 8'h14;
  localparam logic [7:0] OpOutc = 8'h15;
  localparam logic [7:0] OpOr   = 8'h16;
  localparam logic [7:0] OpNot  = 8'h17;
  localparam logic [7:0] OpXor  = 8'h18;
  localparam logic [7:0] OpJn   = 8'h19;
  localparam logic [7:0] OpCall = 8'h20;
  localparam logic [7:0] OpRet  = 8'h21;

  localparam logic [15:0] DataBase  = 16'h8000;
  localparam logic [15:0] StackInit = 16'hFE00;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [10:0] {
    PhIdle  = 11'b000_0000_0001,
    PhOpc   = 11'b000_0000_0010,
    PhOpnd0 = 11'b000_0000_0100,
    PhOpnd1 = 11'b000_0000_1000,
    PhOpnd2 = 11'b000_0001_0000,
    PhLoad  = 11'b000_0010_0000,
    PhStore = 11'b000_0100_0000,
    PhPush1 = 11'b000_1000_0000,
    PhPush2 = 11'b001_0000_0000,
    PhPop1  = 11'b010_0000_0000,
    PhPop2  = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] read_data;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] bus_address;
    logic [15:0] payload;
    logic        bad_opcode;
    logic        last;
  } out_word_t;

  // Number of operand bytes after an opcode; known is low for undefined opcodes.
  typedef struct packed {
    logic       known;
    logic [1:0] count;
  } opnd_info_t;

  function automatic opnd_info_t opnd_info(input logic [7:0] op);
    opnd_info_t r;
    r = '{known: 1'b1, count: 2'd0};
    case (op)
      OpNop, OpHlt, OpRet: r.count = 2'd0;
      OpLdi, OpLd, OpSt, OpJmp, OpCmpi, OpJz, OpJnn, OpAddi, OpCall: r.count = 2'd2;
      OpMov, OpAdd, OpAdc, OpAnd, OpOut, OpLdr, OpStr, OpLdp, OpStp,
      OpOutw, OpOutc, OpOr, OpNot, OpXor: r.count = 2'd1;
      OpJn: r.count = 2'd2;
      OpAddw: r.count = 2'd3;
      default: r.known = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[src/ebc_if.sv]
// Valid/ready channel interfaces for the input and result words of the core.
`default_nettype none
interface ebc_in_if;
  logic              valid;
  logic              ready;
  ebc_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ebc_out_if;
  logic               valid;
  logic               ready;
  ebc_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/eight_bit_cpu_bus_cycle_core.sv]
// Top level of the bus-cycle driven 8-bit processor core.
`default_nettype none
// The core runs one memory-bus cycle per input word: a start word begins
// execution at the program counter, and each returned read byte or write
// acknowledge advances the current instruction. Each input word yields one or
// two result words (a display event followed by the next opcode fetch, or a
// single bus request or halt status), with the final one marked by last.
// An input word is handled in the cycle it is accepted: the decode and
// execute logic updates the architectural state and writes its results into
// a four-entry result queue. A new word is accepted every cycle while the
// queue has room for two more results, so the core sustains one input word
// per cycle as long as results drain; a display instruction puts two words
// in the queue and the queue drain rate then sets the pace. Inputs that do
// not match what the current phase waits for are dropped without effect,
// and after a halt every input is dropped until reset.
module eight_bit_cpu_bus_cycle_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ebc_in_if.sink      in_i,
  ebc_out_if.source   out_o
);

  localparam int unsigned PtrW = $clog2(ebc_pkg::QueueDepth);
  localparam int unsigned CntW = PtrW + 1;

  // Architectural state.
  logic [3:0][7:0]      regs_q, regs_d;
  logic [3:0]           flags_q, flags_d;   // Z N C V from bit 3 down
  logic [15:0]          pc_q, pc_d;
  logic [15:0]          sp_q, sp_d;
  logic                 stopped_q, stopped_d;
  ebc_pkg::phase_e      phase_q, phase_d;
  logic [7:0]           opcode_q, opcode_d;
  logic [2:0][7:0]      opnd_q, opnd_d;

  // Result queue.
  ebc_pkg::out_word_t   queue_q [ebc_pkg::QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      count_q;

  logic                 accept;
  logic                 pop;
  ebc_pkg::out_word_t   res0, res1;
  logic [1:0]           n_res;

  assign in_i.ready  = (count_q <= CntW'(ebc_pkg::QueueDepth - 2));
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = (count_q != '0);
  assign out_o.data  = queue_q[rd_ptr_q];
  assign pop         = out_o.valid && out_o.ready;

  // Decode and execute of one input word.
  always_comb begin
    logic [1:0]             action;
    logic [7:0]             data;
    logic                   do_fetch;
    logic                   do_exec;
    ebc_pkg::opnd_info_t    info;
    logic [1:0]             idx;
    logic [7:0]             b0, b1;
    logic [1:0]             rd, rx, ry, rs;
    logic [15:0]            target;
    logic [15:0]            daddr;
    logic [15:0]            pair;
    logic [8:0]             sum9;
    logic [7:0]             av, bv, lv;
    logic                   cin;
    logic                   do_add;
    logic                   do_logic;
    logic [16:0]            sum17;
    ebc_pkg::out_word_t     r;

    regs_d    = regs_q;
    flags_d   = flags_q;
    pc_d      = pc_q;
    sp_d      = sp_q;
    stopped_d = stopped_q;
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    opnd_d    = opnd_q;
    res0      = '0;
    res1      = '0;
    n_res     = 2'd0;
    do_fetch  = 1'b0;
    do_exec   = 1'b0;
    action    = in_i.data.action;
    data      = in_i.data.read_data;
    info      = ebc_pkg::opnd_info(opcode_q);
    idx       = 2'd0;
    av        = '0;
    bv        = '0;
    lv        = '0;
    cin       = 1'b0;
    do_add    = 1'b0;
    do_logic  = 1'b0;
    sum9      = '0;
    sum17     = '0;
    r         = '0;

    if (accept && !stopped_q) begin
      case (phase_q)
        ebc_pkg::PhIdle: begin
          if (action == ebc_pkg::ActStart) do_fetch = 1'b1;
        end
        ebc_pkg::PhStore: begin
          if (action == ebc_pkg::ActAck) do_fetch = 1'b1;
        end
        ebc_pkg::PhPush1: begin
          if (action == ebc_pkg::ActAck) begin
            res0 = '{kind: ebc_pkg::KindWrite, bus_address: sp_q,
                     payload: {8'h00, pc_q[15:8]}, bad_opcode: 1'b0, last: 1'b0};
            n_res   = 2'd1;
            sp_d    = sp_q - 16'd1;
            phase_d = ebc_pkg::PhPush2;
          end
        end
        ebc_pkg::PhPush2: begin
          if (action == ebc_pkg::ActAck) begin
            pc_d     = {1'b0, opnd_q[0][6:0], opnd_q[1]};
            do_fetch = 1'b1;
          end
        end
        ebc_pkg::PhOpc: begin
          if (action == ebc_pkg::ActRead) begin
            opcode_d = data;
            info     = ebc_pkg::opnd_info(data);
            if (!info.known) begin
              stopped_d = 1'b1;
              res0 = '{kind: ebc_pkg::KindHalt, bus_address: 16'h0000,
                       payload: {8'h00, data}, bad_opcode: 1'b1, last: 1'b0};
              n_res = 2'd1;
            end else if (info.count != 2'd0) begin
              res0 = '{kind: ebc_pkg::KindRead, bus_address: pc_q, payload: 16'h0000,
                       bad_opcode: 1'b0, last: 1'b0};
              n_res   = 2'd1;
              pc_d    = pc_q + 16'd1;
              phase_d = ebc_pkg::PhOpnd0;
            end else begin
              do_exec = 1'b1;
            end
          end
        end
        ebc_pkg::PhOpnd0, ebc_pkg::PhOpnd1, ebc_pkg::PhOpnd2: begin
          if (action == ebc_pkg::ActRead) begin
            idx = (phase_q == ebc_pkg::PhOpnd0) ? 2'd0 :
                  (phase_q == ebc_pkg::PhOpnd1) ? 2'd1 : 2'd2;
            opnd_d[idx] = data;
            if ({1'b0, idx} + 3'd1 < {1'b0, info.count}) begin
              res0 = '{kind: ebc_pkg::KindRead, bus_address: pc_q, payload: 16'h0000,
                       bad_opcode: 1'b0, last: 1'b0};
              n_res   = 2'd1;
              pc_d    = pc_q + 16'd1;
              phase_d = (idx == 2'd0) ? ebc_pkg::PhOpnd1 : ebc_pkg::PhOpnd2;
            end else begin
              do_exec = 1'b1;
            end
          end
        end
        ebc_pkg::PhLoad: begin
          if (action == ebc_pkg::ActRead) begin
            if (opcode_q == ebc_pkg::OpLd) regs_d[opnd_q[0][7:6]] = data;
            else if (opcode_q == ebc_pkg::OpLdr) regs_d[opnd_q[0][3:2]] = data;
            else regs_d[opnd_q[0][5:4]] = data;
            do_fetch = 1'b1;
          end
        end
        ebc_pkg::PhPop1: begin
          if (action == ebc_pkg::ActRead) begin
            opnd_d[0] = data;
            sp_d      = sp_q + 16'd1;
            res0 = '{kind: ebc_pkg::KindRead, bus_address: sp_q + 16'd1,
                     payload: 16'h0000, bad_opcode: 1'b0, last: 1'b0};
            n_res   = 2'd1;
            phase_d = ebc_pkg::PhPop2;
          end
        end
        ebc_pkg::PhPop2: begin
          if (action == ebc_pkg::ActRead) begin
            pc_d     = {opnd_q[0], data};
            do_fetch = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Execute once all operand bytes are in; register file is untouched so far.
    b0     = opnd_d[0];
    b1     = opnd_d[1];
    rd     = b0[5:4];
    rx     = b0[3:2];
    ry     = b0[1:0];
    rs     = b0[7:6];
    target = {1'b0, b0[6:0], b1};
    daddr  = ebc_pkg::DataBase + {2'b00, b0[5:0], b1};
    pair   = b0[0] ? {regs_q[2], regs_q[3]} : {regs_q[0], regs_q[1]};

    if (do_exec) begin
      do_fetch = 1'b1;
      case (opcode_d)
        ebc_pkg::OpNop: ;
        ebc_pkg::OpHlt: begin
          do_fetch  = 1'b0;
          stopped_d = 1'b1;
          res0 = '{kind: ebc_pkg::KindHalt, bus_address: 16'h0000,
                   payload: {8'h00, opcode_d}, bad_opcode: 1'b0, last: 1'b0};
          n_res = 2'd1;
        end
        ebc_pkg::OpLdi: regs_d[ry] = b1;
        ebc_pkg::OpLd, ebc_pkg::OpLdr, ebc_pkg::OpLdp: begin
          do_fetch = 1'b0;
          r.kind   = ebc_pkg::KindRead;
          r.bus_address = (opcode_d == ebc_pkg::OpLd)  ? daddr :
                          (opcode_d == ebc_pkg::OpLdr) ? {8'h00, regs_q[ry]} + ebc_pkg::DataBase
                                                       : pair + ebc_pkg::DataBase;
          res0    = r;
          n_res   = 2'd1;
          phase_d = ebc_pkg::PhLoad;
        end
        ebc_pkg::OpSt, ebc_pkg::OpStr, ebc_pkg::OpStp: begin
          do_fetch = 1'b0;
          r.kind   = ebc_pkg::KindWrite;
          if (opcode_d == ebc_pkg::OpSt) begin
            r.bus_address = daddr;
            r.payload     = {8'h00, regs_q[rs]};
          end else if (opcode_d == ebc_pkg::OpStr) begin
            r.bus_address = {8'h00, regs_q[ry]} + ebc_pkg::DataBase;
            r.payload     = {8'h00, regs_q[rx]};
          end else begin
            r.bus_address = pair + ebc_pkg::DataBase;
            r.payload     = {8'h00, regs_q[rd]};
          end
          res0    = r;
          n_res   = 2'd1;
          phase_d = ebc_pkg::PhStore;
        end
        ebc_pkg::OpMov: regs_d[rx] = regs_q[ry];
        ebc_pkg::OpAdd, ebc_pkg::OpAdc: begin
          do_add = 1'b1;
          av     = regs_q[rx];
          bv     = regs_q[ry];
          cin    = (opcode_d == ebc_pkg::OpAdc) ? flags_q[1] : 1'b0;
        end
        ebc_pkg::OpAddi: begin
          do_add = 1'b1;
          av     = regs_q[ry];
          bv     = b1;
        end
        ebc_pkg::OpAnd: begin
          do_logic = 1'b1;
          lv       = regs_q[ry] & regs_q[rx];
        end
        ebc_pkg::OpOr: begin
          do_logic = 1'b1;
          lv       = regs_q[ry] | regs_q[rx];
        end
        ebc_pkg::OpXor: begin
          do_logic = 1'b1;
          lv       = regs_q[ry] ^ regs_q[rx];
        end
        ebc_pkg::OpNot: begin
          do_logic = 1'b1;
          lv       = ~regs_q[ry];
        end
        ebc_pkg::OpJmp: pc_d = target;
        ebc_pkg::OpJz:  if (flags_q[3]) pc_d = target;
        ebc_pkg::OpJnn: if (!flags_q[2]) pc_d = target;
        ebc_pkg::OpJn:  if (flags_q[2]) pc_d = target;
        ebc_pkg::OpCmpi: begin
          lv         = regs_q[ry] - b1;
          flags_d[3] = (lv == 8'h00);
          flags_d[2] = lv[7];
        end
        ebc_pkg::OpOut, ebc_pkg::OpOutc, ebc_pkg::OpOutw: begin
          r.kind = (opcode_d == ebc_pkg::OpOut)  ? ebc_pkg::KindByte :
                   (opcode_d == ebc_pkg::OpOutc) ? ebc_pkg::KindChar : ebc_pkg::KindPair;
          r.payload = (opcode_d == ebc_pkg::OpOutw) ? pair : {8'h00, regs_q[ry]};
          res0  = r;
          n_res = 2'd1;
        end
        ebc_pkg::OpAddw: begin
          sum17 = {1'b0, pair} + {1'b0, opnd_d[1], opnd_d[2]};
          if (b0[0]) begin
            regs_d[2] = sum17[15:8];
            regs_d[3] = sum17[7:0];
          end else begin
            regs_d[0] = sum17[15:8];
            regs_d[1] = sum17[7:0];
          end
          flags_d[3] = (sum17[15:0] == 16'h0000);
          flags_d[2] = sum17[15];
          flags_d[1] = sum17[16];
        end
        ebc_pkg::OpCall: begin
          do_fetch = 1'b0;
          res0 = '{kind: ebc_pkg::KindWrite, bus_address: sp_q,
                   payload: {8'h00, pc_d[7:0]}, bad_opcode: 1'b0, last: 1'b0};
          n_res   = 2'd1;
          sp_d    = sp_q - 16'd1;
          phase_d = ebc_pkg::PhPush1;
        end
        ebc_pkg::OpRet: begin
          do_fetch = 1'b0;
          sp_d     = sp_q + 16'd1;
          res0 = '{kind: ebc_pkg::KindRead, bus_address: sp_q + 16'd1,
                   payload: 16'h0000, bad_opcode: 1'b0, last: 1'b0};
          n_res   = 2'd1;
          phase_d = ebc_pkg::PhPop1;
        end
        default: ;
      endcase

      if (do_add) begin
        sum9 = {1'b0, av} + {1'b0, bv} + {8'h00, cin};
        flags_d[0] = ~(av[7] ^ bv[7]) & (av[7] ^ sum9[7]);
        flags_d[2] = sum9[7];
        flags_d[3] = (sum9[7:0] == 8'h00);
        flags_d[1] = sum9[8];
        regs_d[(opcode_d == ebc_pkg::OpAddi) ? ry : rd] = sum9[7:0];
      end
      if (do_logic) begin
        regs_d[rd] = lv;
        flags_d[3] = (lv == 8'h00);
        flags_d[2] = lv[7];
      end
    end

    // Opcode fetch that closes an instruction, placed after any display event.
    if (do_fetch) begin
      r = '{kind: ebc_pkg::KindRead, bus_address: pc_d, payload: 16'h0000,
            bad_opcode: 1'b0, last: 1'b0};
      if (n_res == 2'd0) res0 = r;
      else res1 = r;
      n_res   = n_res + 2'd1;
      pc_d    = pc_d + 16'd1;
      phase_d = ebc_pkg::PhOpc;
    end

    if (n_res == 2'd1) res0.last = 1'b1;
    if (n_res == 2'd2) res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q    <= '0;
      flags_q   <= '0;
      pc_q      <= 16'h0000;
      sp_q      <= ebc_pkg::StackInit;
      stopped_q <= 1'b0;
      phase_q   <= ebc_pkg::PhIdle;
      opcode_q  <= '0;
      opnd_q    <= '0;
    end else begin
      regs_q    <= regs_d;
      flags_q   <= flags_d;
      pc_q      <= pc_d;
      sp_q      <= sp_d;
      stopped_q <= stopped_d;
      phase_q   <= phase_d;
      opcode_q  <= opcode_d;
      opnd_q    <= opnd_d;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + CntW'(n_res) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) queue_q[wr_ptr_q] <= res0;
    if (n_res == 2'd2) queue_q[wr_ptr_q + PtrW'(1)] <= res1;
  end

  // The queue never holds more words than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ebc_pkg::QueueDepth))
    else $error("result queue overflow");

  // A halted core produces nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (n_res == 2'd0))
    else $error("results after halt");

  // A pair of results is always a display event followed by an opcode fetch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_res == 2'd2) |-> (res1.kind == ebc_pkg::KindRead && phase_d == ebc_pkg::PhOpc &&
                         (res0.kind == ebc_pkg::KindByte || res0.kind == ebc_pkg::KindPair ||
                          res0.kind == ebc_pkg::KindChar)))
    else $error("unexpected result pair");

endmodule
`default_nettype wire

[sim/eight_bit_cpu_bus_cycle_core_tb.sv]
// Self-checking testbench for the bus-cycle driven 8-bit processor core.
`default_nettype none
module eight_bit_cpu_bus_cycle_core_tb;
  import ebc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ebc_in_if  in_if ();
  ebc_out_if out_if ();

  eight_bit_cpu_bus_cycle_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the architectural state of the core.
  logic [7:0]  sh_regs [4];
  logic [3:0]  sh_flags;            // Z N C V from bit 3 down to bit 0.
  logic [15:0] sh_pc;
  logic [15:0] sh_sp;
  logic        sh_halted;
  phase_e      sh_phase;
  logic [7:0]  sh_op;
  logic [7:0]  sh_opnd [3];

  out_word_t bus_words_due [$];     // Result words still to come out, oldest first.
  out_word_t step_words [$];        // Words caused by the word being predicted.

  int words_sent;
  int words_checked;
  int mismatches;
  bit send_burst;
  bit recv_burst;

  // Number of operand bytes after an opcode, or -1 for an undefined opcode.
  function automatic int operand_len(input logic [7:0] op);
    case (op)
      OpNop, OpHlt, OpRet: return 0;
      OpMov, OpAdd, OpAdc, OpAnd, OpOut, OpLdr, OpStr, OpLdp, OpStp,
      OpOutw, OpOutc, OpOr, OpNot, OpXor: return 1;
      OpAddw: return 3;
      OpLdi, OpLd, OpSt, OpJmp, OpCmpi, OpJz, OpJnn, OpAddi, OpJn, OpCall: return 2;
      default: return -1;
    endcase
  endfunction

  function automatic logic [15:0] reg_pair(input logic [7:0] sel);
    return {sh_regs[{sel[0], 1'b0}], sh_regs[{sel[0], 1'b1}]};
  endfunction

  function automatic logic [15:0] jump_target();
    return {1'b0, sh_opnd[0][6:0], sh_opnd[1]};
  endfunction

  task automatic emit(input logic [2:0] kind, input logic [15:0] addr,
                      input logic [15:0] pay, input logic bad);
    step_words.push_back('{kind: kind, bus_address: addr, payload: pay,
                           bad_opcode: bad, last: 1'b0});
  endtask

  task automatic fetch_next();
    emit(KindRead, sh_pc, 16'h0000, 1'b0);
    sh_pc++;
    sh_phase = PhOpc;
  endtask

  task automatic stop_core(input logic bad);
    sh_halted = 1'b1;
    emit(KindHalt, 16'h0000, {8'h00, sh_op}, bad);
  endtask

  task automatic set_zn(input logic [7:0] v);
    sh_flags[3] = (v == 8'h00);
    sh_flags[2] = v[7];
  endtask

  task automatic add_bytes(input logic [1:0] dst, input logic [7:0] a,
                           input logic [7:0] b, input logic cin);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + {8'h00, cin};
    sh_flags[0] = ~(a[7] ^ b[7]) & (a[7] ^ s[7]);
    sh_flags[2] = s[7];
    sh_flags[3] = (s[7:0] == 8'h00);
    sh_flags[1] = s[8];
    sh_regs[dst] = s[7:0];
  endtask

  // Runs the current instruction once all of its operand bytes are in.
  task automatic run_instruction();
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [1:0]  d;
    logic [1:0]  x;
    logic [1:0]  y;
    logic [16:0] wide;
    logic [15:0] data_addr;
    bit          then_fetch;
    b0 = sh_opnd[0];
    b1 = sh_opnd[1];
    d = b0[5:4];
    x = b0[3:2];
    y = b0[1:0];
    data_addr = DataBase + {2'b00, b0[5:0], b1};
    then_fetch = 1'b1;
    case (sh_op)
      OpNop: ;
      OpHlt: begin stop_core(1'b0); then_fetch = 1'b0; end
      OpLdi: sh_regs[y] = b1;
      OpLd: begin
        emit(KindRead, data_addr, 16'h0000, 1'b0);
        sh_phase = PhLoad;
        then_fetch = 1'b0;
      end
      OpSt: begin
        emit(KindWrite, data_addr, {8'h00, sh_regs[b0[7:6]]}, 1'b0);
        sh_phase = PhStore;
        then_fetch = 1'b0;
      end
      OpMov: sh_regs[x] = sh_regs[y];
      OpAdd: add_bytes(d, sh_regs[x], sh_regs[y], 1'b0);
      OpAdc: add_bytes(d, sh_regs[x], sh_regs[y], sh_flags[1]);
      OpAnd: begin sh_regs[d] = sh_regs[y] & sh_regs[x]; set_zn(sh_regs[d]); end
      OpJmp: sh_pc = jump_target();
      OpOut: emit(KindByte, 16'h0000, {8'h00, sh_regs[y]}, 1'b0);
      OpCmpi: set_zn(sh_regs[y] - b1);
      OpJz: if (sh_flags[3]) sh_pc = jump_target();
      OpJnn: if (!sh_flags[2]) sh_pc = jump_target();
      OpJn: if (sh_flags[2]) sh_pc = jump_target();
      OpLdr: begin
        emit(KindRead, DataBase + {8'h00, sh_regs[y]}, 16'h0000, 1'b0);
        sh_phase = PhLoad;
        then_fetch = 1'b0;
      end
      OpStr: begin
        emit(KindWrite, DataBase + {8'h00, sh_regs[y]}, {8'h00, sh_regs[x]}, 1'b0);
        sh_phase = PhStore;
        then_fetch = 1'b0;
      end
      OpLdp: begin
        emit(KindRead, reg_pair(b0) + DataBase, 16'h0000, 1'b0);
        sh_phase = PhLoad;
        then_fetch = 1'b0;
      end
      OpStp: begin
        emit(KindWrite, reg_pair(b0) + DataBase, {8'h00, sh_regs[d]}, 1'b0);
        sh_phase = PhStore;
        then_fetch = 1'b0;
      end
      OpAddw: begin
        wide = {1'b0, reg_pair(b0)} + {1'b0, sh_opnd[1], sh_opnd[2]};
        sh_regs[{b0[0], 1'b0}] = wide[15:8];
        sh_regs[{b0[0], 1'b1}] = wide[7:0];
        sh_flags[3] = (wide[15:0] == 16'h0000);
        sh_flags[2] = wide[15];
        sh_flags[1] = wide[16];
      end
      OpAddi: add_bytes(y, sh_regs[y], b1, 1'b0);
      OpOutw: emit(KindPair, 16'h0000, reg_pair(b0), 1'b0);
      OpOutc: emit(KindChar, 16'h0000, {8'h00, sh_regs[y]}, 1'b0);
      OpOr: begin sh_regs[d] = sh_regs[y] | sh_regs[x]; set_zn(sh_regs[d]); end
      OpNot: begin sh_regs[d] = ~sh_regs[y]; set_zn(sh_regs[d]); end
      OpXor: begin sh_regs[d] = sh_regs[y] ^ sh_regs[x]; set_zn(sh_regs[d]); end
      OpCall: begin
        emit(KindWrite, sh_sp, {8'h00, sh_pc[7:0]}, 1'b0);
        sh_sp--;
        sh_phase = PhPush1;
        then_fetch = 1'b0;
      end
      OpRet: begin
        sh_sp++;
        emit(KindRead, sh_sp, 16'h0000, 1'b0);
        sh_phase = PhPop1;
        then_fetch = 1'b0;
      end
      default: begin stop_core(1'b1); then_fetch = 1'b0; end
    endcase
    if (then_fetch) fetch_next();
  endtask

  // Advances the shadow core by one accepted input word and queues its results.
  task automatic predict_bus_step(input logic [1:0] act, input logic [7:0] rd);
    int idx;
    step_words.delete();
    if (!sh_halted) begin
      case (sh_phase)
        PhIdle: if (act == ActStart) fetch_next();
        PhStore: if (act == ActAck) fetch_next();
        PhPush1: if (act == ActAck) begin
          emit(KindWrite, sh_sp, {8'h00, sh_pc[15:8]}, 1'b0);
          sh_sp--;
          sh_phase = PhPush2;
        end
        PhPush2: if (act == ActAck) begin
          sh_pc = jump_target();
          fetch_next();
        end
        PhOpc: if (act == ActRead) begin
          sh_op = rd;
          if (operand_len(rd) < 0) stop_core(1'b1);
          else if (operand_len(rd) > 0) begin
            emit(KindRead, sh_pc, 16'h0000, 1'b0);
            sh_pc++;
            sh_phase = PhOpnd0;
          end else run_instruction();
        end
        PhOpnd0, PhOpnd1, PhOpnd2: if (act == ActRead) begin
          idx = (sh_phase == PhOpnd0) ? 0 : (sh_phase == PhOpnd1) ? 1 : 2;
          sh_opnd[idx] = rd;
          if (idx + 1 < operand_len(sh_op)) begin
            emit(KindRead, sh_pc, 16'h0000, 1'b0);
            sh_pc++;
            sh_phase = (idx == 0) ? PhOpnd1 : PhOpnd2;
          end else run_instruction();
        end
        PhLoad: if (act == ActRead) begin
          if (sh_op == OpLd) sh_regs[sh_opnd[0][7:6]] = rd;
          else if (sh_op == OpLdr) sh_regs[sh_opnd[0][3:2]] = rd;
          else sh_regs[sh_opnd[0][5:4]] = rd;
          fetch_next();
        end
        PhPop1: if (act == ActRead) begin
          sh_opnd[0] = rd;
          sh_sp++;
          emit(KindRead, sh_sp, 16'h0000, 1'b0);
          sh_phase = PhPop2;
        end
        PhPop2: if (act == ActRead) begin
          sh_pc = {sh_opnd[0], rd};
          fetch_next();
        end
        default: ;
      endcase
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) bus_words_due.push_back(step_words[i]);
  endtask

  // Drives one input word after a random gap and predicts it once accepted.
  task automatic send_word(input logic [1:0] act, input logic [7:0] rd);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{action: act, read_data: rd};
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    words_sent++;
    predict_bus_step(act, rd);
  endtask

  // The action that the current phase waits for.
  function automatic logic [1:0] awaited_action();
    case (sh_phase)
      PhIdle: return ActStart;
      PhStore, PhPush1, PhPush2: return ActAck;
      default: return ActRead;
    endcase
  endfunction

  // A defined opcode other than HLT, so that the core keeps running.
  function automatic logic [7:0] running_opcode();
    int r;
    r = $urandom_range(0, 26);
    if (r == 0) return OpNop;
    if (r == 25) return OpCall;
    if (r == 26) return OpRet;
    return OpHlt + 8'(r);
  endfunction

  // Answers the pending bus request as memory would, with some noise mixed in.
  task automatic send_program_words(input int count);
    logic [1:0] act;
    logic [1:0] wrong;
    int sent;
    sent = 0;
    while (sent < count) begin
      act = awaited_action();
      if ($urandom_range(0, 9) == 0) begin
        // A word the current phase does not wait for is dropped by the core.
        do wrong = 2'($urandom_range(0, 3)); while (wrong == act);
        send_word(wrong, 8'($urandom_range(0, 255)));
      end else begin
        send_word(act, (sh_phase == PhOpc) ? running_opcode()
                                            : 8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  task automatic test_directed_program();
    send_word(ActStart, 8'h00);
    send_word(ActStart, 8'h00);          // start while running is ignored
    send_word(ActRead, OpLdi);
    send_word(ActRead, 8'h00);
    send_word(ActRead, 8'hFF);           // R0 = 0xFF
    send_word(ActRead, OpAddi);
    send_word(ActRead, 8'h00);
    send_word(ActRead, 8'h01);           // R0 wraps to zero with carry
    send_word(ActRead, OpOutw);
    send_word(ActRead, 8'h00);
    send_word(ActRead, OpNot);
    send_word(ActRead, 8'h13);           // R1 = ~R3
    send_word(ActRead, OpSt);
    send_word(ActRead, 8'hFF);
    send_word(ActRead, 8'hFF);
    send_word(2'd3, 8'hFF);              // action 3 is ignored
    send_word(ActAck, 8'h00);
    send_word(ActRead, OpCall);
    send_word(ActRead, 8'hFF);
    send_word(ActRead, 8'hFF);
    send_word(ActAck, 8'h00);
    send_word(ActAck, 8'h00);
    send_word(ActRead, OpRet);
    send_word(ActRead, 8'h12);
    send_word(ActRead, 8'h34);
  endtask

  task automatic test_random_program();
    send_program_words(430);
  endtask

  // Halts with HLT or an undefined opcode; nothing after that has any effect.
  task automatic test_halt();
    logic [7:0] op;
    while (sh_phase != PhOpc) send_program_words(1);
    if ($urandom_range(0, 1) == 0) op = OpHlt;
    else do op = 8'($urandom_range(8'h1A, 8'hFF)); while (op == OpCall || op == OpRet);
    send_word(ActRead, op);
    send_word(ActStart, 8'h00);
    send_word(ActRead, OpNop);
    send_word(ActAck, 8'h00);
    in_if.valid <= 1'b0;
  endtask

  // Result side: random stalls between accepted words.
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
    end
  end

  // Each accepted result word is matched against the oldest expected one.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      words_checked++;
      if (bus_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word kind=%0d addr=%h payload=%h bad=%b last=%b",
                   out_if.data.kind, out_if.data.bus_address, out_if.data.payload,
                   out_if.data.bad_opcode, out_if.data.last);
      end else begin
        want = bus_words_due.pop_front();
        if (out_if.data.kind !== want.kind || out_if.data.bus_address !== want.bus_address
            || out_if.data.payload !== want.payload
            || out_if.data.bad_opcode !== want.bad_opcode
            || out_if.data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind=%0d addr=%h payload=%h bad=%b last=%b, %s",
                     want.kind, want.bus_address, want.payload, want.bad_opcode,
                     want.last, $sformatf("got kind=%0d addr=%h payload=%h bad=%b last=%b",
                     out_if.data.kind, out_if.data.bus_address, out_if.data.payload,
                     out_if.data.bad_opcode, out_if.data.last));
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout waiting for result words");
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    sh_regs = '{default: 8'h00};
    sh_opnd = '{default: 8'h00};
    sh_flags = 4'h0;
    sh_pc = 16'h0000;
    sh_sp = StackInit;
    sh_halted = 1'b0;
    sh_phase = PhIdle;
    sh_op = OpNop;
    words_sent = 0;
    words_checked = 0;
    mismatches = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_program();
    test_random_program();
    test_halt();
    while (bus_words_due.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d input words and checked %0d result words,", words_sent,
             words_checked);
    $display("covering directed and random programs, bus noise and a final halt.");
    if (mismatches == 0 && bus_words_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatching result words", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
